### rtl/core/bpmq_pkg.sv
// Package for the bounded priority message queue.
// Holds sizes, entry and command types, status and operation codes.
// No dependencies.
package bpmq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int MAX_MSG_BYTES = 8;
  localparam int PRIO_W        = 8;
  localparam int LEN_W         = 4;
  localparam int PAYLOAD_W     = 64;
  localparam int COUNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int IN_TDATA_W    = 80;
  localparam int OUT_TDATA_W   = 80;
  localparam int STATUS_W      = 2;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_PULL = 1'b1
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [PRIO_W-1:0]    prio;
    logic [LEN_W-1:0]     len;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic   push;
    logic   pull;
    entry_t ent;
  } cmd_t;

  // saturate length and clear bytes at and above it
  function automatic entry_t make_entry(logic [PRIO_W-1:0] prio, logic [LEN_W-1:0] len,
                                        logic [PAYLOAD_W-1:0] payload);
    entry_t e;
    logic [LEN_W-1:0] l;
    l = (len > LEN_W'(MAX_MSG_BYTES)) ? LEN_W'(MAX_MSG_BYTES) : len;
    e.prio = prio;
    e.len  = l;
    for (int b = 0; b < PAYLOAD_W / 8; b++) begin
      e.payload[b*8 +: 8] = (LEN_W'(b) < l) ? payload[b*8 +: 8] : 8'd0;
    end
    return e;
  endfunction

endpackage

### rtl/core/bpmq_cell.sv
// One slot of the sorted shift queue.
// Holds, takes the pushed word, or shifts from either neighbor; depends on bpmq_pkg.
module bpmq_cell (
  input  logic              clk,
  input  logic              occ,
  input  bpmq_pkg::cmd_t    cmd,
  input  logic              left_keep,
  input  bpmq_pkg::entry_t  left_ent,
  input  bpmq_pkg::entry_t  right_ent,
  output logic              keep,
  output bpmq_pkg::entry_t  ent
);

  bpmq_pkg::entry_t ent_next;

  // entry stays when it ranks at or above the new word
  assign keep = occ && (ent.prio >= cmd.ent.prio);

  always_comb begin
    ent_next = ent;
    priority if (cmd.push) begin
      priority if (keep) begin
        ent_next = ent;
      end else if (left_keep) begin
        ent_next = cmd.ent;
      end else begin
        ent_next = left_ent;
      end
    end else if (cmd.pull) begin
      ent_next = right_ent;
    end else begin
      ent_next = ent;
    end
  end

  always_ff @(posedge clk) begin
    ent <= ent_next;
  end

endmodule

### rtl/core/bounded_priority_message_queue.sv
// Bounded priority message queue, top level.
// Uses bpmq_pkg and a row of bpmq_cell slots.
//
// Usage:
//   Input stream s_*: s_tuser selects push (0) or pull (1); s_tdata carries
//   priority, length and payload of a pushed word. Output stream m_*: one
//   word per input word with status in m_tuser, the pulled entry and the
//   full/empty flags in m_tdata.
//   Slots sit in a row sorted by descending priority, head in slot 0. Every
//   slot compares its priority to the pushed one in parallel, so the insert
//   is a single shift step; a pull shifts the row toward the head.
//   The result word is registered and valid in the cycle after the input is taken.
//   Throughput: one word per cycle while m_tready is high, set by the single shift step of the row.
//   The output register frees in the cycle it is read, so s_tready stays
//   high as long as m_tready is high.
//   Reset clears the count and the output valid; slot contents are left as is.
//   When the receiver stalls, the result word holds and s_tready drops until
//   it is taken.
module bounded_priority_message_queue (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [7:0] priority_req, [11:8] msg_length, [75:12] payload, [79:76] zero
  input  logic [bpmq_pkg::IN_TDATA_W-1:0]    s_tdata,
  // [0] func
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [7:0] out_priority, [11:8] out_length, [75:12] out_payload,
  // [76] is_full, [77] is_empty, [79:78] zero
  output logic [bpmq_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // [1:0] status
  output logic [bpmq_pkg::STATUS_W-1:0]      m_tuser
);

  localparam int Depth = bpmq_pkg::QUEUE_DEPTH;
  localparam int CntW  = bpmq_pkg::COUNT_W;

  logic [CntW-1:0]      count;
  logic [CntW-1:0]      count_next;
  logic                 accept;
  logic                 is_full;
  logic                 is_empty;
  bpmq_pkg::cmd_t       cmd;
  bpmq_pkg::entry_t     ent  [Depth];
  logic                 keep [Depth];
  bpmq_pkg::status_t    status_next;
  bpmq_pkg::entry_t     res_next;
  logic                 m_tvalid_next;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign is_full  = (count == CntW'(Depth));
  assign is_empty = (count == '0);

  always_comb begin
    cmd.push = accept && (s_tuser == bpmq_pkg::FUNC_PUSH) && !is_full;
    cmd.pull = accept && (s_tuser == bpmq_pkg::FUNC_PULL) && !is_empty;
    cmd.ent  = bpmq_pkg::make_entry(s_tdata[7:0], s_tdata[11:8], s_tdata[75:12]);
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic              occ;
    logic              lk;
    bpmq_pkg::entry_t  le;
    bpmq_pkg::entry_t  re;
    assign occ = (count > CntW'(i));
    if (i == 0) begin : g_head
      assign lk = 1'b0;
      assign le = cmd.ent;
    end else begin : g_mid
      assign lk = keep[i-1];
      assign le = ent[i-1];
    end
    if (i == Depth - 1) begin : g_tail
      assign re = ent[i];
    end else begin : g_body
      assign re = ent[i+1];
    end
    bpmq_cell u_cell (
      .clk       (clk),
      .occ       (occ),
      .cmd       (cmd),
      .left_keep (lk),
      .left_ent  (le),
      .right_ent (re),
      .keep      (keep[i]),
      .ent       (ent[i])
    );
  end

  always_comb begin
    count_next  = count;
    status_next = bpmq_pkg::STAT_OK;
    res_next    = '0;
    if (cmd.push) begin
      count_next = count + CntW'(1);
    end else if (cmd.pull) begin
      count_next = count - CntW'(1);
      res_next   = ent[0];
    end
    if (accept && (s_tuser == bpmq_pkg::FUNC_PUSH) && is_full) begin
      status_next = bpmq_pkg::STAT_FULL;
    end else if (accept && (s_tuser == bpmq_pkg::FUNC_PULL) && is_empty) begin
      status_next = bpmq_pkg::STAT_EMPTY;
    end
    m_tvalid_next = accept ? 1'b1 : (m_tvalid && !m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count    <= count_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tuser <= status_next;
      m_tdata <= {2'b00, (count_next == '0), (count_next == CntW'(Depth)),
                  res_next.payload, res_next.len, res_next.prio};
    end
  end

endmodule

### rtl/core/bpmq_chk.sv
// Port-level checker for the bounded priority message queue.
// Depends on bpmq_pkg; bound to bounded_priority_message_queue below.
module bpmq_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_tready,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [bpmq_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input logic [bpmq_pkg::STATUS_W-1:0]      m_tuser
);

  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output word changed");

  a_no_take_stalled: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output stalled");

  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[76] && m_tdata[77]))
    else $error("queue flagged full and empty");

  a_refused_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == bpmq_pkg::STAT_FULL) |-> m_tdata[76] && (m_tdata[75:0] == '0))
    else $error("refused push without full flag or with data");

endmodule

bind bounded_priority_message_queue bpmq_chk u_bpmq_chk (.*);
